// ----- hdl/cafu_pkg.sv -----
// Shared types, codes and sizes for the CPU ALU and flags unit.
package cafu_pkg;

	localparam logic [4:0] KIND_ADD  = 5'd0;
	localparam logic [4:0] KIND_ADC  = 5'd1;
	localparam logic [4:0] KIND_SUB  = 5'd2;
	localparam logic [4:0] KIND_SBC  = 5'd3;
	localparam logic [4:0] KIND_AND  = 5'd4;
	localparam logic [4:0] KIND_XOR  = 5'd5;
	localparam logic [4:0] KIND_OR   = 5'd6;
	localparam logic [4:0] KIND_CP   = 5'd7;
	localparam logic [4:0] KIND_INC  = 5'd8;
	localparam logic [4:0] KIND_DEC  = 5'd9;
	localparam logic [4:0] KIND_DAA  = 5'd10;
	localparam logic [4:0] KIND_CPL  = 5'd11;
	localparam logic [4:0] KIND_SCF  = 5'd12;
	localparam logic [4:0] KIND_CCF  = 5'd13;
	localparam logic [4:0] KIND_RLC  = 5'd14;
	localparam logic [4:0] KIND_RRC  = 5'd15;
	localparam logic [4:0] KIND_RL   = 5'd16;
	localparam logic [4:0] KIND_RR   = 5'd17;
	localparam logic [4:0] KIND_SLA  = 5'd18;
	localparam logic [4:0] KIND_SRA  = 5'd19;
	localparam logic [4:0] KIND_SRL  = 5'd20;
	localparam logic [4:0] KIND_SWAP = 5'd21;
	localparam logic [4:0] KIND_BIT  = 5'd22;
	localparam logic [4:0] KIND_RES  = 5'd23;
	localparam logic [4:0] KIND_SET  = 5'd24;
	localparam logic [4:0] KIND_RLCA = 5'd25;
	localparam logic [4:0] KIND_RRCA = 5'd26;
	localparam logic [4:0] KIND_RLA  = 5'd27;
	localparam logic [4:0] KIND_RRA  = 5'd28;
	localparam logic [4:0] KIND_WORD = 5'd29;

	localparam logic [1:0] WMODE_ADD_HL = 2'd0;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [4:0] {
		OP_ADD,
		OP_ADC,
		OP_SUB,
		OP_SBC,
		OP_AND,
		OP_XOR,
		OP_OR,
		OP_CP,
		OP_INC,
		OP_DEC,
		OP_DAA,
		OP_CPL,
		OP_SCF,
		OP_CCF,
		OP_SHIFT_REG,
		OP_SHIFT_ACC,
		OP_BIT,
		OP_RES,
		OP_SET,
		OP_ADD_HL,
		OP_ADD_SP,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		SH_RLC,
		SH_RRC,
		SH_RL,
		SH_RR,
		SH_SLA,
		SH_SRA,
		SH_SRL,
		SH_SWAP
	} shift_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		op_t         op;
		shift_t      sh;
		logic [7:0]  operand;
		logic [7:0]  mask;
		logic [15:0] word_base;
		logic [15:0] word_addend;
		logic [7:0]  offset;
	} item_t;

endpackage

// ----- hdl/cpu_alu_flags_unit.sv -----
// Top level of the CPU ALU and flags unit: front end, item queue and execution stage.
//
// The unit takes one operation per input transaction on the in_valid / in_stall
// channel and returns one result transaction on the out_valid / out_stall channel.
// A transaction is taken at a rising edge where valid is high and stall is low.
// The accumulator and the four flags live inside the unit; every result carries
// the result word, the flags and the accumulator as they stand after the operation.
// An operation accepted at an edge is written into the queue, then computed from the
// queue head and held in the output register. Throughput is one operation per cycle
// while the receiver does not stall, set by the ALU and flag path in the execution
// stage; the two-entry queue between the front end and the execution stage keeps the
// input taking new transactions while a result waits in the output register.
// When the receiver stalls, the result holds and the queue fills; once it is full
// in_stall rises until the receiver takes the waiting result.
// Reset clears the accumulator, the flags, the queue and the output valid flag.
module cpu_alu_flags_unit import cafu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [4:0]        kind,
	input  logic [7:0]        byte_operand,
	input  logic [2:0]        bit_index,
	input  logic [15:0]       word_base,
	input  logic [15:0]       word_addend,
	input  logic signed [7:0] signed_offset,
	input  logic [1:0]        word_mode,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       result_word,
	output logic [3:0]        flags_out,
	output logic [7:0]        accumulator_out
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  head_valid;
	item_t head_item;
	logic  pop;

	cafu_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.byte_operand  (byte_operand),
		.bit_index     (bit_index),
		.word_base     (word_base),
		.word_addend   (word_addend),
		.signed_offset (signed_offset),
		.word_mode     (word_mode),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	cafu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	cafu_exec u_exec (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_item       (head_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_word     (result_word),
		.flags_out       (flags_out),
		.accumulator_out (accumulator_out)
	);

endmodule

// ----- hdl/cafu_front.sv -----
// Front end: accepts input transactions and classifies them into decoded items.
module cafu_front import cafu_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [4:0]        kind,
	input  logic [7:0]        byte_operand,
	input  logic [2:0]        bit_index,
	input  logic [15:0]       word_base,
	input  logic [15:0]       word_addend,
	input  logic signed [7:0] signed_offset,
	input  logic [1:0]        word_mode,
	input  logic              q_full,
	output logic              push,
	output item_t             push_item
);

	op_t    op;
	shift_t sh;

	always_comb begin
		op = OP_NOP;
		sh = SH_RLC;
		unique case (kind)
			KIND_ADD:  op = OP_ADD;
			KIND_ADC:  op = OP_ADC;
			KIND_SUB:  op = OP_SUB;
			KIND_SBC:  op = OP_SBC;
			KIND_AND:  op = OP_AND;
			KIND_XOR:  op = OP_XOR;
			KIND_OR:   op = OP_OR;
			KIND_CP:   op = OP_CP;
			KIND_INC:  op = OP_INC;
			KIND_DEC:  op = OP_DEC;
			KIND_DAA:  op = OP_DAA;
			KIND_CPL:  op = OP_CPL;
			KIND_SCF:  op = OP_SCF;
			KIND_CCF:  op = OP_CCF;
			KIND_RLC:  begin op = OP_SHIFT_REG; sh = SH_RLC;  end
			KIND_RRC:  begin op = OP_SHIFT_REG; sh = SH_RRC;  end
			KIND_RL:   begin op = OP_SHIFT_REG; sh = SH_RL;   end
			KIND_RR:   begin op = OP_SHIFT_REG; sh = SH_RR;   end
			KIND_SLA:  begin op = OP_SHIFT_REG; sh = SH_SLA;  end
			KIND_SRA:  begin op = OP_SHIFT_REG; sh = SH_SRA;  end
			KIND_SRL:  begin op = OP_SHIFT_REG; sh = SH_SRL;  end
			KIND_SWAP: begin op = OP_SHIFT_REG; sh = SH_SWAP; end
			KIND_BIT:  op = OP_BIT;
			KIND_RES:  op = OP_RES;
			KIND_SET:  op = OP_SET;
			KIND_RLCA: begin op = OP_SHIFT_ACC; sh = SH_RLC;  end
			KIND_RRCA: begin op = OP_SHIFT_ACC; sh = SH_RRC;  end
			KIND_RLA:  begin op = OP_SHIFT_ACC; sh = SH_RL;   end
			KIND_RRA:  begin op = OP_SHIFT_ACC; sh = SH_RR;   end
			KIND_WORD: op = (word_mode == WMODE_ADD_HL) ? OP_ADD_HL : OP_ADD_SP;
			default:   op = OP_NOP;
		endcase
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.op          = op;
		push_item.sh          = sh;
		push_item.operand     = byte_operand;
		push_item.mask        = 8'd1 << bit_index;
		push_item.word_base   = word_base;
		push_item.word_addend = word_addend;
		push_item.offset      = signed_offset;
	end

endmodule

// ----- hdl/cafu_queue.sv -----
// Short queue of decoded items between the front end and the execution stage.
module cafu_queue import cafu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  head_valid,
	output item_t head_item,
	input  logic  pop
);

	item_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not rise on a lone push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not fall on a lone pop");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue took a transaction while full");
`endif

endmodule

// ----- hdl/cafu_exec.sv -----
// Execution stage: holds the accumulator and flags and computes each operation.
module cafu_exec import cafu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  item_t       head_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] result_word,
	output logic [3:0]  flags_out,
	output logic [7:0]  accumulator_out
);

	logic [7:0]  acc_q;
	flags_t      flags_q;
	logic        out_valid_q;
	logic [15:0] res_q;

	logic [7:0]  next_acc;
	flags_t      next_f;
	logic [15:0] next_res;

	function automatic logic [8:0] shift_byte(shift_t code, logic [7:0] v, logic cin);
		logic [8:0] r;
		unique case (code)
			SH_RLC:  r = {v[7], v[6:0], v[7]};
			SH_RRC:  r = {v[0], v[0], v[7:1]};
			SH_RL:   r = {v[7], v[6:0], cin};
			SH_RR:   r = {v[0], cin, v[7:1]};
			SH_SLA:  r = {v[7], v[6:0], 1'b0};
			SH_SRA:  r = {v[0], v[7], v[7:1]};
			SH_SRL:  r = {v[0], 1'b0, v[7:1]};
			SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
		endcase
		return r;
	endfunction

	always_comb begin
		logic [7:0]  a;
		logic [7:0]  r;
		logic        ci;
		logic [8:0]  sum9;
		logic [4:0]  lo5;
		logic [7:0]  v8;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic        adj_hi;
		logic [8:0]  sh9;
		logic [16:0] sum17;
		logic [12:0] sum13;
		logic [15:0] ext;

		a        = acc_q;
		r        = head_item.operand;
		ci       = 1'b0;
		sum9     = '0;
		lo5      = '0;
		v8       = '0;
		d1       = '0;
		d2       = '0;
		adj_hi   = 1'b0;
		sh9      = '0;
		sum17    = '0;
		sum13    = '0;
		ext      = '0;
		next_acc = acc_q;
		next_f   = flags_q;
		next_res = {8'h00, acc_q};

		unique case (head_item.op)
			OP_ADD, OP_ADC: begin
				ci       = (head_item.op == OP_ADC) && flags_q.c;
				sum9     = {1'b0, a} + {1'b0, r} + {8'h00, ci};
				lo5      = {1'b0, a[3:0]} + {1'b0, r[3:0]} + {4'h0, ci};
				next_acc = sum9[7:0];
				next_f   = '{z: (sum9[7:0] == 8'h00), n: 1'b0, h: lo5[4], c: sum9[8]};
				next_res = {8'h00, sum9[7:0]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				ci     = (head_item.op == OP_SBC) && flags_q.c;
				sum9   = {1'b0, a} - {1'b0, r} - {8'h00, ci};
				lo5    = {1'b0, a[3:0]} - {1'b0, r[3:0]} - {4'h0, ci};
				next_f = '{z: (sum9[7:0] == 8'h00), n: 1'b1, h: lo5[4], c: sum9[8]};
				if (head_item.op != OP_CP) begin
					next_acc = sum9[7:0];
					next_res = {8'h00, sum9[7:0]};
				end
			end
			OP_AND: begin
				v8       = a & r;
				next_acc = v8;
				next_f   = '{z: (v8 == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
				next_res = {8'h00, v8};
			end
			OP_XOR: begin
				v8       = a ^ r;
				next_acc = v8;
				next_f   = '{z: (v8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
				next_res = {8'h00, v8};
			end
			OP_OR: begin
				v8       = a | r;
				next_acc = v8;
				next_f   = '{z: (v8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
				next_res = {8'h00, v8};
			end
			OP_INC: begin
				v8       = r + 8'd1;
				next_f   = '{z: (v8 == 8'h00), n: 1'b0, h: (r[3:0] == 4'hf), c: flags_q.c};
				next_res = {8'h00, v8};
			end
			OP_DEC: begin
				v8       = r - 8'd1;
				next_f   = '{z: (v8 == 8'h00), n: 1'b1, h: (r[3:0] == 4'h0), c: flags_q.c};
				next_res = {8'h00, v8};
			end
			OP_DAA: begin
				if (!flags_q.n) begin
					adj_hi = flags_q.c || (a > 8'h99);
					d1     = adj_hi ? a + 8'h60 : a;
					d2     = (flags_q.h || (d1[3:0] > 4'h9)) ? d1 + 8'h06 : d1;
				end else begin
					d1 = flags_q.c ? a - 8'h60 : a;
					d2 = flags_q.h ? d1 - 8'h06 : d1;
				end
				next_acc = d2;
				next_f   = '{z: (d2 == 8'h00), n: flags_q.n, h: 1'b0, c: flags_q.c || adj_hi};
				next_res = {8'h00, d2};
			end
			OP_CPL: begin
				v8       = ~a;
				next_acc = v8;
				next_f   = '{z: flags_q.z, n: 1'b1, h: 1'b1, c: flags_q.c};
				next_res = {8'h00, v8};
			end
			OP_SCF: begin
				next_f = '{z: flags_q.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			OP_CCF: begin
				next_f = '{z: flags_q.z, n: 1'b0, h: 1'b0, c: !flags_q.c};
			end
			OP_SHIFT_REG: begin
				sh9      = shift_byte(head_item.sh, r, flags_q.c);
				next_f   = '{z: (sh9[7:0] == 8'h00), n: 1'b0, h: 1'b0, c: sh9[8]};
				next_res = {8'h00, sh9[7:0]};
			end
			OP_SHIFT_ACC: begin
				sh9      = shift_byte(head_item.sh, a, flags_q.c);
				next_acc = sh9[7:0];
				next_f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh9[8]};
				next_res = {8'h00, sh9[7:0]};
			end
			OP_BIT: begin
				next_f   = '{z: ((r & head_item.mask) == 8'h00), n: 1'b0, h: 1'b1,
					c: flags_q.c};
				next_res = {8'h00, r};
			end
			OP_RES: begin
				next_res = {8'h00, r & ~head_item.mask};
			end
			OP_SET: begin
				next_res = {8'h00, r | head_item.mask};
			end
			OP_ADD_HL: begin
				sum17    = {1'b0, head_item.word_base} + {1'b0, head_item.word_addend};
				sum13    = {1'b0, head_item.word_base[11:0]} +
					{1'b0, head_item.word_addend[11:0]};
				next_f   = '{z: flags_q.z, n: 1'b0, h: sum13[12], c: sum17[16]};
				next_res = sum17[15:0];
			end
			OP_ADD_SP: begin
				ext      = {{8{head_item.offset[7]}}, head_item.offset};
				sum9     = {1'b0, head_item.word_base[7:0]} + {1'b0, head_item.offset};
				lo5      = {1'b0, head_item.word_base[3:0]} + {1'b0, head_item.offset[3:0]};
				next_f   = '{z: 1'b0, n: 1'b0, h: lo5[4], c: sum9[8]};
				next_res = head_item.word_base + ext;
			end
			OP_NOP: begin
				next_res = {8'h00, acc_q};
			end
		endcase
	end

	assign pop = head_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q       <= next_acc;
				flags_q     <= next_f;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= next_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_word     = res_q;
	assign flags_out       = flags_q;
	assign accumulator_out = acc_q;

`ifndef SYNTHESIS
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("executed item did not reach the output register");
	a_nop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.op == OP_NOP) |=> ($stable(acc_q) && $stable(flags_q)))
		else $error("unused operation changed the accumulator or flags");
	a_bitop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (head_item.op == OP_RES || head_item.op == OP_SET)) |=>
		($stable(flags_q) && $stable(acc_q)))
		else $error("bit reset or set changed the accumulator or flags");
`endif

endmodule
